FILE: rtl/core/sliding_median_filter_3axis_macros.svh
// Assertion macros for the sliding median filter.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SLIDING_MEDIAN_FILTER_3AXIS_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_3AXIS_MACROS_SVH

// property checked every clock, off while in reset
`define SMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define SMF_ASSERT_IMP(lbl, ante, cons, msg) \
  `SMF_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define SMF_ASSERT_NXT(lbl, ante, cons, msg) \
  `SMF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/smf_pkg.sv
// Package for the sliding median filter: defaults and neighbor link type.
// No dependencies.
package smf_pkg;

  localparam int unsigned WINDOW_DEF      = 15;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned AXES            = 3;

  // flags one sorted cell hands to its neighbors
  typedef struct packed {
    logic le;    // stored value <= incoming sample
    logic gone;  // oldest entry sits in this cell or below
  } smf_flags_t;

endpackage

FILE: rtl/core/sliding_median_filter_3axis.sv
// Top level of the three-axis sliding median filter: stream ports, result stage.
// Depends on smf_pkg, smf_axis and the assertion macro header.
//
// Takes one magnetometer sample (x, y, z) per clock unless back-pressure stalls
// the input, and returns, for each axis, the median of the latest WINDOW samples,
// zeros filling the window after reset. Each axis is a chain of WINDOW sorted
// cells that drops the oldest entry and inserts the new one in the same cycle,
// so a new sample is taken every cycle while not stalled; the chain updates on
// the accepting edge, the output register when the result advances. For an even
// window the median is the floor of the mean of the two middle entries.
`include "sliding_median_filter_3axis_macros.svh"

module sliding_median_filter_3axis import smf_pkg::*; #(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // mag_x, mag_y, mag_z, zero pad
  input  logic [((AXES*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // median_x, median_y, median_z, zero pad
  output logic [((AXES*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned TDATA_W = ((AXES * SAMPLE_BITS + 7) / 8) * 8;

  logic signed [SAMPLE_BITS-1:0] mag_x, mag_y, mag_z;
  logic signed [SAMPLE_BITS-1:0] median_x, median_y, median_z;
  logic                          s_fire, adv;
  logic                          p1_v_q, p1_v_d;
  logic                          out_v_q, out_v_d;
  logic [AXES*SAMPLE_BITS-1:0]   out_q;

  assign mag_x = s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign mag_y = s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign mag_z = s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];

  // p1: cell chains hold the state after the last request
  assign adv           = p1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !p1_v_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  smf_axis #(.SAMPLE_BITS(SAMPLE_BITS), .WINDOW(WINDOW)) u_axis_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .load_i (s_fire),
    .sample_i (mag_x), .median_o (median_x)
  );

  smf_axis #(.SAMPLE_BITS(SAMPLE_BITS), .WINDOW(WINDOW)) u_axis_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .load_i (s_fire),
    .sample_i (mag_y), .median_o (median_y)
  );

  smf_axis #(.SAMPLE_BITS(SAMPLE_BITS), .WINDOW(WINDOW)) u_axis_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .load_i (s_fire),
    .sample_i (mag_z), .median_o (median_z)
  );

  always_comb begin
    p1_v_d = p1_v_q;
    if (s_fire) begin
      p1_v_d = 1'b1;
    end else if (adv) begin
      p1_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (adv) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      p1_v_q  <= p1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {median_z, median_y, median_x};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = TDATA_W'(out_q);

  `SMF_ASSERT_IMP(a_stall_blocks, p1_v_q && out_v_q && !m_axis_tready, !s_axis_tready, "input taken while both stages are full")
  `SMF_ASSERT_NXT(a_fire_fills, s_fire, p1_v_q, "accepted request not held in chain stage")
  `SMF_ASSERT_NXT(a_adv_fills, adv, out_v_q, "advanced result not shown at output")

endmodule

FILE: rtl/core/smf_cell.sv
// One cell of the sorted window chain: a value and its age.
// Depends on smf_pkg.
module smf_cell import smf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned AGE_BITS    = $clog2(WINDOW),
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_val_i,
  input  logic        [AGE_BITS-1:0]    prev_age_i,
  input  smf_flags_t                    prev_flags_i,
  input  logic signed [SAMPLE_BITS-1:0] next_val_i,
  input  logic        [AGE_BITS-1:0]    next_age_i,
  input  smf_flags_t                    next_flags_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic        [AGE_BITS-1:0]    age_o,
  output smf_flags_t                    flags_o
);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic        [AGE_BITS-1:0]    age_q, age_d;
  logic                          le, del, gone;
  logic signed [SAMPLE_BITS-1:0] cur_val, low_val;
  logic        [AGE_BITS-1:0]    cur_age, low_age;
  logic                          cur_le, low_le;

  assign le   = (val_q <= sample_i);
  assign del  = (age_q == AGE_BITS'(WINDOW - 1));
  assign gone = prev_flags_i.gone | del;

  // entry at this place once the oldest is dropped, and the one below it
  assign cur_val = gone ? next_val_i : val_q;
  assign cur_age = gone ? next_age_i : age_q;
  assign cur_le  = gone ? next_flags_i.le : le;
  assign low_val = prev_flags_i.gone ? val_q : prev_val_i;
  assign low_age = prev_flags_i.gone ? age_q : prev_age_i;
  assign low_le  = prev_flags_i.gone ? le : prev_flags_i.le;

  always_comb begin
    if (cur_le) begin
      val_d = cur_val;
      age_d = cur_age + AGE_BITS'(1);
    end else if (low_le) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = low_val;
      age_d = low_age + AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AGE_BITS'(INDEX);
    end else if (load_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o        = val_q;
  assign age_o        = age_q;
  assign flags_o.le   = le;
  assign flags_o.gone = gone;

endmodule

FILE: rtl/core/smf_axis.sv
// Sorted cell chain for one axis, with median pick from the middle cells.
// Depends on smf_pkg, smf_cell and the assertion macro header.
`include "sliding_median_filter_3axis_macros.svh"

module smf_axis import smf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned WINDOW      = WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] median_o
);

  localparam int unsigned AGE_BITS = $clog2(WINDOW);
  localparam int unsigned MID      = WINDOW / 2;

  logic signed [SAMPLE_BITS-1:0] vals [WINDOW];
  logic        [AGE_BITS-1:0]    ages [WINDOW];
  smf_flags_t                    flgs [WINDOW];
  logic        [WINDOW-1:0]      del_vec, new_vec;
  logic        [WINDOW-2:0]      ordered;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] pv, nv;
    logic        [AGE_BITS-1:0]    pa, na;
    smf_flags_t                    pf, nf;

    if (i == 0) begin : g_first
      assign pv = '0;
      assign pa = '0;
      assign pf = '{le: 1'b1, gone: 1'b0};
    end else begin : g_mid_lo
      assign pv = vals[i-1];
      assign pa = ages[i-1];
      assign pf = flgs[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign nv = '0;
      assign na = '0;
      assign nf = '{le: 1'b0, gone: 1'b1};
    end else begin : g_mid_hi
      assign nv = vals[i+1];
      assign na = ages[i+1];
      assign nf = flgs[i+1];
    end

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW      (WINDOW),
      .AGE_BITS    (AGE_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (load_i),
      .sample_i     (sample_i),
      .prev_val_i   (pv),
      .prev_age_i   (pa),
      .prev_flags_i (pf),
      .next_val_i   (nv),
      .next_age_i   (na),
      .next_flags_i (nf),
      .val_o        (vals[i]),
      .age_o        (ages[i]),
      .flags_o      (flgs[i])
    );

    assign del_vec[i] = (ages[i] == AGE_BITS'(WINDOW - 1));
    assign new_vec[i] = (ages[i] == '0);
    if (i < WINDOW - 1) begin : g_ord
      assign ordered[i] = (vals[i] <= vals[i+1]);
    end
  end

  if (WINDOW % 2 != 0) begin : g_odd
    assign median_o = vals[MID];
  end else begin : g_even
    logic signed [SAMPLE_BITS:0] sum;
    // floor of the mean of the two middle entries
    assign sum      = {vals[MID-1][SAMPLE_BITS-1], vals[MID-1]}
                    + {vals[MID][SAMPLE_BITS-1], vals[MID]};
    assign median_o = sum[SAMPLE_BITS:1];
  end

  `SMF_ASSERT(a_one_oldest, $onehot(del_vec), "exactly one cell must hold the oldest entry")
  `SMF_ASSERT(a_one_newest, $onehot(new_vec), "exactly one cell must hold the newest entry")
  `SMF_ASSERT(a_sorted, &ordered, "cell chain lost ascending order")

endmodule
